[rtl/gamepad_report_unpacker_core_defines.svh]
// assertion macros for the report unpacker rtl
`ifndef GAMEPAD_REPORT_UNPACKER_CORE_DEFINES_SVH
`define GAMEPAD_REPORT_UNPACKER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define GRU_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("report unpacker check failed");

// condition implies consequence in the next cycle
`define GRU_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("report unpacker check failed");

`endif

[rtl/gru_pkg.sv]
// shared types, result kind codes and axis normalization for the report unpacker
package gru_pkg;

  // result kind codes
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;
  localparam logic [1:0] KIND_DPAD   = 2'd3;

  // results still owed for one report byte
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         index;
    logic [3:0]         count;
    logic [7:0]         data;
    logic signed [17:0] value;
    logic [7:0]         cid;
    logic               done;
  } run_t;

  // signed 16-bit axis to q.16: negative as v*2, positive as round(v*65536/32767)
  // v*65536 = 2*32767*v + 2v, so the quotient is 2v plus a 0..2 correction
  function automatic logic signed [17:0] axis_norm(input logic [15:0] raw);
    logic [17:0] x;
    logic [1:0]  extra;
    logic [17:0] res;
    x     = {1'b0, raw, 1'b0} + 18'd16383;
    extra = 2'({1'b0, (x >= 18'd32767)} + {1'b0, (x >= 18'd65534)});
    if (raw[15] || (raw == 16'd0)) begin
      res = {raw[15], raw, 1'b0};
    end else begin
      res = {1'b0, raw, 1'b0} + {16'd0, extra};
    end
    return signed'(res);
  endfunction

endpackage

[rtl/gru_parse.sv]
// report position tracking and per-byte result run decode
module gru_parse import gru_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_value_i,
  input  logic       start_of_packet_i,
  output run_t       run_o
);

  logic [9:0] pos_q, pos_d;
  logic [7:0] cid_q, cid_d;
  logic [7:0] axis_total_q, axis_total_d;
  logic [7:0] button_total_q, button_total_d;
  logic [7:0] dpad_total_q, dpad_total_d;
  logic [7:0] axis_hi_q, axis_hi_d;
  logic       finished_q, finished_d;

  logic [9:0] axes_end, buttons_end, report_end, pos_inc, rel, grp_btn, grp_dpad;
  logic [8:0] btn_sum, dpad_sum;
  logic [7:0] dpad_eff, base_btn, base_dpad, left_btn, left_dpad;
  logic       ends_here;
  run_t       run;

  // section boundaries of the report
  always_comb begin
    dpad_eff    = (pos_q == 10'd3) ? byte_value_i : dpad_total_q;
    btn_sum     = {1'b0, button_total_q} + 9'd7;
    dpad_sum    = {1'b0, dpad_eff} + 9'd1;
    axes_end    = 10'd4 + {1'b0, axis_total_q, 1'b0};
    buttons_end = axes_end + {4'd0, btn_sum[8:3]};
    report_end  = buttons_end + {2'd0, dpad_sum[8:1]};
    pos_inc     = pos_q + 10'd1;
    rel         = pos_q - 10'd4;
    grp_btn     = pos_q - axes_end;
    grp_dpad    = pos_q - buttons_end;
    base_btn    = {grp_btn[4:0], 3'b000};
    base_dpad   = {grp_dpad[6:0], 1'b0};
    left_btn    = button_total_q - base_btn;
    left_dpad   = dpad_total_q - base_dpad;
    ends_here   = (pos_q >= 10'd3) && (pos_inc >= report_end);
  end

  // decode one byte into state updates and a result run
  always_comb begin
    pos_d          = pos_q;
    cid_d          = cid_q;
    axis_total_d   = axis_total_q;
    button_total_d = button_total_q;
    dpad_total_d   = dpad_total_q;
    axis_hi_d      = axis_hi_q;
    finished_d     = finished_q;
    run            = '0;
    run.cid        = cid_q;
    run.data       = byte_value_i;
    if (start_of_packet_i) begin
      cid_d      = byte_value_i;
      pos_d      = 10'd1;
      finished_d = 1'b0;
    end else if (!finished_q) begin
      if (pos_q == 10'd1) begin
        axis_total_d = byte_value_i;
      end else if (pos_q == 10'd2) begin
        button_total_d = byte_value_i;
      end else if (pos_q == 10'd3) begin
        dpad_total_d = byte_value_i;
        run.kind     = KIND_HEADER;
        run.count    = 4'd1;
      end else if (pos_q < axes_end) begin
        if (!rel[0]) begin
          axis_hi_d = byte_value_i;
        end else begin
          run.kind  = KIND_AXIS;
          run.index = rel[8:1];
          run.count = 4'd1;
          run.value = axis_norm({axis_hi_q, byte_value_i});
        end
      end else if (pos_q < buttons_end) begin
        run.kind  = KIND_BUTTON;
        run.index = base_btn;
        run.count = (left_btn > 8'd8) ? 4'd8 : left_btn[3:0];
      end else begin
        run.kind  = KIND_DPAD;
        run.index = base_dpad;
        run.count = (left_dpad > 8'd1) ? 4'd2 : 4'd1;
      end
      pos_d = pos_inc;
      if (ends_here) begin
        finished_d = 1'b1;
        run.done   = 1'b1;
      end
    end
  end

  assign run_o = run;

  // report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      cid_q          <= '0;
      axis_total_q   <= '0;
      button_total_q <= '0;
      dpad_total_q   <= '0;
      axis_hi_q      <= '0;
      finished_q     <= 1'b1;
    end else if (accept_i) begin
      pos_q          <= pos_d;
      cid_q          <= cid_d;
      axis_total_q   <= axis_total_d;
      button_total_q <= button_total_d;
      dpad_total_q   <= dpad_total_d;
      axis_hi_q      <= axis_hi_d;
      finished_q     <= finished_d;
    end
  end

endmodule

[rtl/gamepad_report_unpacker_core.sv]
// top level of the controller report unpacker: byte decode, result run and output register
// each result of a byte passes through the pending run register, then the output register
// throughput: one result per cycle while out_stall_i is low; the input stalls while a byte's
//   results (up to eight for a button byte) are still owed to the single output register
// a byte that gives no result leaves nothing pending; a byte is taken while the previous result waits
// reset: asynchronous, active low; the block then ignores bytes until a start byte arrives
`include "gamepad_report_unpacker_core_defines.svh"

module gamepad_report_unpacker_core import gru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_value_i,
  input  logic               start_of_packet_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         index_o,
  output logic signed [17:0] value_o,
  output logic [7:0]         controller_id_o,
  output logic               last_of_run_o,
  output logic               packet_done_o
);

  run_t               new_run;
  run_t               run_q, run_d;
  logic               in_xfer, out_load;
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [7:0]         index_q, cid_q;
  logic signed [17:0] value_q, value_d;
  logic               last_q, done_q;

  gru_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_xfer),
    .byte_value_i      (byte_value_i),
    .start_of_packet_i (start_of_packet_i),
    .run_o             (new_run)
  );

  // handshake: a byte is taken once the pending run is empty or hands over its last result
  assign out_load   = (run_q.count != 4'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (run_q.count > 4'd1) || ((run_q.count == 4'd1) && !out_load);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // value of the result at the head of the run
  always_comb begin
    case (run_q.kind)
      KIND_BUTTON: value_d = signed'({17'd0, run_q.data[7]});
      KIND_DPAD:   value_d = signed'({14'd0, run_q.data[7:4]});
      default:     value_d = run_q.value;
    endcase
  end

  // next run: a new byte's run, or the current one advanced by one result
  always_comb begin
    run_d = run_q;
    if (in_xfer) begin
      run_d = new_run;
    end else if (out_load) begin
      run_d.count = run_q.count - 4'd1;
      run_d.index = run_q.index + 8'd1;
      run_d.data  = (run_q.kind == KIND_DPAD) ? {run_q.data[3:0], 4'd0}
                                              : {run_q.data[6:0], 1'b0};
    end
  end

  // pending run register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= run_q.kind;
      index_q <= run_q.index;
      value_q <= value_d;
      cid_q   <= run_q.cid;
      last_q  <= (run_q.count == 4'd1);
      done_q  <= run_q.done && (run_q.count == 4'd1);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign index_o         = index_q;
  assign value_o         = value_q;
  assign controller_id_o = cid_q;
  assign last_of_run_o   = last_q;
  assign packet_done_o   = done_q;

  // checks
  `GRU_ASSERT_IMPLY(a_run_bounded, clk_i, rst_ni, 1'b1, run_q.count <= 4'd8)
  `GRU_ASSERT_IMPLY(a_xfer_run_free, clk_i, rst_ni, in_xfer, run_q.count <= 4'd1)
  `GRU_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_q)
  `GRU_ASSERT_IMPLY(a_done_is_last, clk_i, rst_ni, out_valid_q && done_q, last_q)

endmodule

[bench/gamepad_report_unpacker_core_test.sv]
// self-checking bench for the controller report unpacker: directed reports, random reports, noise
module gamepad_report_unpacker_core_test import gru_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // one unpacked field as it leaves the block
  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         index;
    logic signed [17:0] value;
    logic [7:0]         cid;
    logic               last;
    logic               done;
  } report_result_t;

  // tracks report decode state and the fields still owed by the block
  class unpack_scoreboard;
    logic [9:0]     position;
    logic [7:0]     cid;
    logic [7:0]     n_axes;
    logic [7:0]     n_buttons;
    logic [7:0]     n_dpads;
    logic [7:0]     axis_hi;
    bit             finished;
    report_result_t pending_fields[$];
    int             failures;

    function new();
      position  = '0;
      cid       = '0;
      n_axes    = '0;
      n_buttons = '0;
      n_dpads   = '0;
      axis_hi   = '0;
      finished  = 1'b1;
      failures  = 0;
    endfunction

    function report_result_t make_result(logic [1:0] k, logic [7:0] idx,
                                         logic signed [17:0] val);
      report_result_t r;
      r.kind  = k;
      r.index = idx;
      r.value = val;
      r.cid   = cid;
      r.last  = 1'b0;
      r.done  = 1'b0;
      return r;
    endfunction

    // predict the fields caused by one accepted byte transfer
    function void note_byte(logic [7:0] b, logic sop);
      report_result_t    run[8];
      int                n;
      int                j;
      int                v;
      int unsigned       p;
      int unsigned       axes_end;
      int unsigned       buttons_end;
      int unsigned       report_end;
      int unsigned       base;
      int unsigned       cnt;
      logic signed [17:0] q16;
      n = 0;
      if (sop) begin
        cid      = b;
        position = 10'd1;
        finished = 1'b0;
        return;
      end
      // stray bytes outside a report
      if (finished) return;
      p = position;

      // header counts; the dpad count closes the header
      if (p == 1) begin
        n_axes = b;
      end else if (p == 2) begin
        n_buttons = b;
      end else if (p == 3) begin
        n_dpads = b;
        run[n] = make_result(KIND_HEADER, 8'd0, 18'sd0);
        n++;
      end

      axes_end    = 4 + 2 * n_axes;
      buttons_end = axes_end + ((n_buttons + 7) >> 3);
      report_end  = buttons_end + ((n_dpads + 1) >> 1);

      // payload section
      if (p >= 4) begin
        if (p < axes_end) begin
          if (((p - 4) & 1) == 0) begin
            axis_hi = b;
          end else begin
            v = $signed({axis_hi, b});
            if (v <= 0) q16 = 18'(v * 2);
            else q16 = 18'((longint'(v) * 65536 + 16383) / 32767);
            run[n] = make_result(KIND_AXIS, 8'((p - 4) >> 1), q16);
            n++;
          end
        end else if (p < buttons_end) begin
          base = (p - axes_end) * 8;
          cnt  = n_buttons - base;
          if (cnt > 8) cnt = 8;
          for (j = 0; j < cnt; j++) begin
            run[n] = make_result(KIND_BUTTON, 8'(base + j), 18'(b[7 - j]));
            n++;
          end
        end else begin
          base = (p - buttons_end) * 2;
          cnt  = n_dpads - base;
          run[n] = make_result(KIND_DPAD, 8'(base), 18'(b[7:4]));
          n++;
          if (cnt > 1) begin
            run[n] = make_result(KIND_DPAD, 8'(base + 1), 18'(b[3:0]));
            n++;
          end
        end
      end

      position = 10'(p + 1);
      if (p >= 3 && p + 1 >= report_end) begin
        finished = 1'b1;
        if (n > 0) run[n - 1].done = 1'b1;
      end
      if (n > 0) run[n - 1].last = 1'b1;
      for (j = 0; j < n; j++) pending_fields.push_back(run[j]);
    endfunction

    // compare one output transfer with the oldest predicted field
    function void check_result(report_result_t got);
      report_result_t want;
      if (pending_fields.size() == 0) begin
        $error("unexpected result: kind %0d index %0d value %0d", got.kind, got.index,
               got.value);
        failures++;
        return;
      end
      want = pending_fields.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.index !== want.index) begin
        $error("index: expected %0d, got %0d", want.index, got.index);
        failures++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        failures++;
      end
      if (got.cid !== want.cid) begin
        $error("controller_id: expected %0d, got %0d", want.cid, got.cid);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
        failures++;
      end
      if (got.done !== want.done) begin
        $error("packet_done: expected %0d, got %0d", want.done, got.done);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         byte_val = 8'd0;
  logic               sop = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         kind;
  logic [7:0]         index;
  logic signed [17:0] value;
  logic [7:0]         controller_id;
  logic               last_of_run;
  logic               packet_done;

  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  int sent = 0;

  unpack_scoreboard sb = new();

  gamepad_report_unpacker_core uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .byte_value_i     (byte_val),
    .start_of_packet_i(sop),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .index_o          (index),
    .value_o          (value),
    .controller_id_o  (controller_id),
    .last_of_run_o    (last_of_run),
    .packet_done_o    (packet_done)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // sender idles between transfers: mostly none or short, now and then long
  task automatic idle_gap();
    int r;
    int len;
    r   = $urandom_range(0, 99);
    len = 0;
    if (!no_gaps) begin
      if (r >= 92) len = $urandom_range(8, 30);
      else if (r >= 60) len = $urandom_range(1, 3);
    end
    if (len > 0) begin
      in_valid <= 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  // offer one byte at the falling edge and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic s);
    in_valid <= 1'b1;
    byte_val <= b;
    sop      <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, s);
    sent++;
    @(negedge clk);
    idle_gap();
  endtask

  // complete report with random axis, button and dpad content
  task automatic send_report(input logic [7:0] id, input logic [7:0] axes,
                             input logic [7:0] buttons, input logic [7:0] dpads);
    int nbytes;
    nbytes = 2 * axes + (buttons + 7) / 8 + (dpads + 1) / 2;
    send_byte(id, 1'b1);
    send_byte(axes, 1'b0);
    send_byte(buttons, 1'b0);
    send_byte(dpads, 1'b0);
    repeat (nbytes) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // check every output transfer
  always @(posedge clk) begin : watch_results
    report_result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind  = kind;
      seen.index = index;
      seen.value = value;
      seen.cid   = controller_id;
      seen.last  = last_of_run;
      seen.done  = packet_done;
      sb.check_result(seen);
    end
  end

  // receiver stalls: short and long, quiet stretches, one long hold on request
  initial begin
    int r;
    int len;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        holding = 1'b0;
      end
      r   = $urandom_range(0, 99);
      len = (r < 15) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      repeat (len) @(negedge clk);
      r   = $urandom_range(0, 99);
      len = (r < 10) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (len) @(negedge clk);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, directed reports, pressure, random traffic, drain
  initial begin
    int r;
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // byte before any start is dropped
    send_byte(8'hA5, 1'b0);
    // empty report, then a byte past its end
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3C, 1'b0);
    // four axes (both range extremes, zero and one), 11 buttons, 3 dpads
    send_byte(8'h00, 1'b1);
    send_byte(8'd4, 1'b0);
    send_byte(8'd11, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hF0, 1'b0);
    // report cut off by the next start
    send_byte(8'h42, 1'b1);
    send_byte(8'd2, 1'b0);

    // long receiver hold while a button-heavy report keeps coming
    in_valid <= 1'b0;
    hold_req = 1'b1;
    wait (holding);
    @(negedge clk);
    no_gaps = 1'b1;
    send_report(8'h5A, 8'd0, 8'd64, 8'd0);

    // random traffic: mostly well-formed reports, some broken ones and noise
    while (sent < 160) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_report(8'($urandom), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 20)),
                    8'($urandom_range(0, 5)));
      end else if (r < 90) begin
        k = $urandom_range(1, 6);
        send_byte(8'($urandom), 1'b1);
        repeat (k) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding fields, then idle a while for stray output
    while (sb.pending_fields.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
